// File: hw/rtl/dkpc_pkg.sv
// Package for the detent knob PID commutator: constants, register indexes and tables.
// Depends on nothing; used by dkpc_serial_mac and the top level.
package dkpc_pkg;

    localparam int unsigned Detents = 3;
    localparam int unsigned IdxW = 4;

    localparam logic [31:0] IntegK = 32'd26986;
    localparam logic [31:0] PropK = 32'd411775;

    // Register indexes on the configuration port.
    localparam logic [2:0] RegPropGain  = 3'd0;
    localparam logic [2:0] RegIntegGain = 3'd1;
    localparam logic [2:0] RegDerivGain = 3'd2;
    localparam logic [2:0] RegIntegLim  = 3'd3;
    localparam logic [2:0] RegVoltLim   = 3'd4;
    localparam logic [2:0] RegDeadBand  = 3'd5;
    localparam logic [2:0] RegJumpThr   = 3'd6;

    // Center of detent idx in turn units: floor(idx * 65536 / Detents), as a constant table.
    function automatic logic [15:0] f_centre(input logic [IdxW-1:0] idx);
        logic [15:0] c;
        c = '0;
        for (int k = 0; k < 16; k++) begin
            if (idx == IdxW'(k)) begin
                c = 16'((k * 65536) / Detents);
            end
        end
        return c;
    endfunction

    function automatic logic [5:0] f_gates(input logic [3:0] sector);
        logic [5:0] g;
        case (sector)
            4'd0: g = 6'h24;
            4'd1: g = 6'h25;
            4'd2: g = 6'h21;
            4'd3: g = 6'h29;
            4'd4: g = 6'h09;
            4'd5: g = 6'h19;
            4'd6: g = 6'h18;
            4'd7: g = 6'h1A;
            4'd8: g = 6'h12;
            4'd9: g = 6'h16;
            4'd10: g = 6'h06;
            4'd11: g = 6'h26;
            default: g = 6'h00;
        endcase
        return g;
    endfunction

    // Request to the bit-serial multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] mcand;
        logic [31:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] prod;
    } t_mul_rsp;

endpackage

// File: hw/rtl/dkpc_serial_mac.sv
// Bit-serial unsigned multiplier: one multiplier bit per cycle.
// Depends on dkpc_pkg for the request and response structs.
module dkpc_serial_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dkpc_pkg::t_mul_req i_req,
    output dkpc_pkg::t_mul_rsp o_rsp
);
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mcand, n_mcand;
    logic [31:0] r_mplier, n_mplier;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    always_comb begin
        n_acc = r_acc;
        n_mcand = r_mcand;
        n_mplier = r_mplier;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_acc = '0;
            n_mcand = i_req.mcand;
            n_mplier = i_req.mplier;
            n_cnt = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand = {r_mcand[62:0], 1'b0};
            n_mplier = {1'b0, r_mplier[31:1]};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_mcand <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
endmodule

// File: hw/rtl/detent_knob_pid_commutator_unit.sv
// Detent knob position PID with twelve-step bridge commutation, top level.
// Depends on dkpc_pkg and dkpc_serial_mac.
//
// One request is worked at a time. A valid sample passes through five products
// (integral step in two, then P, I and D), each through the shared bit-serial
// multiplier (a start, the serial bit steps and taking the product), and through
// single states for the error, the integral clamp, rounding, commutation and the
// handoff to the output register. No new request is taken until the unit is back
// in idle after the handoff. An invalid sample goes straight to the handoff. A
// result held in the output register stalls the handoff of the next one until it
// leaves.
module detent_knob_pid_commutator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_mech_angle,
    input  logic [15:0] i_elec_angle,
    input  logic signed [15:0] i_speed,
    input  logic [15:0] i_elapsed_us,
    input  logic        i_sample_ok,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_gate_pattern,
    output logic signed [15:0] o_drive_voltage,
    output logic [3:0]  o_detent,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StErr   = 4'd1;
    localparam logic [3:0] StInc1  = 4'd2;
    localparam logic [3:0] StInc2  = 4'd3;
    localparam logic [3:0] StIntg  = 4'd4;
    localparam logic [3:0] StP     = 4'd5;
    localparam logic [3:0] StI     = 4'd6;
    localparam logic [3:0] StD     = 4'd7;
    localparam logic [3:0] StRound = 4'd8;
    localparam logic [3:0] StOut   = 4'd9;
    localparam logic [3:0] StWait  = 4'd10;

    // Configuration registers.
    logic [15:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [17:0] r_integ_limit;
    logic [14:0] r_volt_limit, r_jump_thr;
    logic [11:0] r_dead_band;

    logic cfg_wr;
    logic [2:0] cfg_idx;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain <= 16'd5120;
            r_integ_gain <= 16'd128;
            r_deriv_gain <= 16'd115;
            r_integ_limit <= 18'd65536;
            r_volt_limit <= 15'd8192;
            r_dead_band <= 12'd205;
            r_jump_thr <= 15'd2731;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dkpc_pkg::RegPropGain:  r_prop_gain <= pwdata[15:0];
                dkpc_pkg::RegIntegGain: r_integ_gain <= pwdata[15:0];
                dkpc_pkg::RegDerivGain: r_deriv_gain <= pwdata[15:0];
                dkpc_pkg::RegIntegLim:  r_integ_limit <= pwdata[17:0];
                dkpc_pkg::RegVoltLim:   r_volt_limit <= pwdata[14:0];
                dkpc_pkg::RegDeadBand:  r_dead_band <= pwdata[11:0];
                dkpc_pkg::RegJumpThr:   r_jump_thr <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            dkpc_pkg::RegPropGain:  prdata = {16'd0, r_prop_gain};
            dkpc_pkg::RegIntegGain: prdata = {16'd0, r_integ_gain};
            dkpc_pkg::RegDerivGain: prdata = {16'd0, r_deriv_gain};
            dkpc_pkg::RegIntegLim:  prdata = {14'd0, r_integ_limit};
            dkpc_pkg::RegVoltLim:   prdata = {17'd0, r_volt_limit};
            dkpc_pkg::RegDeadBand:  prdata = {20'd0, r_dead_band};
            dkpc_pkg::RegJumpThr:   prdata = {17'd0, r_jump_thr};
            default: prdata = '0;
        endcase
    end

    // Control and state.
    logic [3:0] r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic signed [19:0] r_integ, n_integ;
    logic [15:0] r_mech, r_elec, r_us;
    logic signed [15:0] r_speed;
    logic signed [16:0] r_err, n_err;
    logic signed [19:0] r_new_integ, n_new_integ;
    logic signed [63:0] r_sum, n_sum;
    logic [63:0] r_tmp, n_tmp;
    logic signed [15:0] r_v, n_v;
    logic r_ovalid;
    logic [5:0] r_gates, n_gates;
    logic [3:0] r_odet;
    logic signed [15:0] r_ov;
    logic [5:0] r_ogates;

    dkpc_pkg::t_mul_req mreq;
    dkpc_pkg::t_mul_rsp mrsp;

    dkpc_serial_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .o_rsp  (mrsp)
    );

    logic in_acc, out_acc;
    assign o_stall = (r_state != StIdle);
    assign in_acc = i_valid & ~o_stall;
    assign out_acc = r_ovalid & ~i_stall;

    function automatic logic signed [16:0] f_err(input logic [15:0] mech,
                                                 input logic [3:0] idx);
        logic [15:0] d;
        d = mech - dkpc_pkg::f_centre(idx);
        return 17'(signed'(d));
    endfunction

    logic signed [16:0] e0;
    logic [3:0] idx_up, idx_dn;
    logic signed [16:0] thr;
    logic [16:0] abs_err;
    logic [63:0] abs_sum, rnd;
    logic signed [20:0] integ_t;
    logic signed [19:0] lim;
    logic [15:0] drv;
    logic [19:0] sect_prod;
    logic [15:0] abs_v;
    logic signed [16:0] vlim;
    logic signed [28:0] vfull;

    always_comb begin
        e0 = f_err(r_mech, r_idx);
        idx_up = (r_idx == 4'(dkpc_pkg::Detents - 1)) ? 4'd0 : r_idx + 4'd1;
        idx_dn = (r_idx == 4'd0) ? 4'(dkpc_pkg::Detents - 1) : r_idx - 4'd1;
        thr = 17'(r_jump_thr);
        abs_err = r_err[16] ? 17'(-r_err) : 17'(r_err);
        abs_sum = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
        rnd = (abs_sum + (64'd1 << 27)) >> 28;
        vfull = r_sum[63] ? 29'(rnd) : -29'(rnd);
        lim = 20'(r_integ_limit);
        vlim = 17'(r_volt_limit);
        integ_t = '0;
        drv = '0;
        sect_prod = '0;
        abs_v = '0;

        n_state = r_state;
        n_idx = r_idx;
        n_integ = r_integ;
        n_err = r_err;
        n_new_integ = r_new_integ;
        n_sum = r_sum;
        n_tmp = r_tmp;
        n_v = r_v;
        n_gates = r_gates;
        mreq = '0;

        case (r_state)
            StIdle: begin
                if (in_acc) begin
                    n_state = i_sample_ok ? StErr : StWait;
                    n_v = '0;
                    n_gates = '0;
                end
            end
            StErr: begin
                if (e0 > thr) begin
                    n_idx = idx_up;
                    n_err = f_err(r_mech, idx_up);
                    n_integ = '0;
                end else if (e0 < -thr) begin
                    n_idx = idx_dn;
                    n_err = f_err(r_mech, idx_dn);
                    n_integ = '0;
                end else begin
                    n_err = e0;
                end
                n_state = StInc1;
            end
            StInc1: begin
                // |err| * us first; the constant follows.
                if (!mrsp.busy && !mrsp.done) begin
                    mreq.start = 1'b1;
                    mreq.mcand = 64'(abs_err);
                    mreq.mplier = 32'(r_us);
                end else if (mrsp.done) begin
                    n_tmp = mrsp.prod;
                    n_state = StInc2;
                end
            end
            StInc2: begin
                if (!mrsp.busy && !mrsp.done) begin
                    mreq.start = 1'b1;
                    mreq.mcand = r_tmp;
                    mreq.mplier = dkpc_pkg::IntegK;
                end else if (mrsp.done) begin
                    n_tmp = (mrsp.prod + (64'd1 << 31)) >> 32;
                    n_state = StIntg;
                end
            end
            StIntg: begin
                integ_t = r_err[16] ? 21'(r_integ) - 21'(r_tmp[19:0])
                                    : 21'(r_integ) + 21'(r_tmp[19:0]);
                if (integ_t > 21'(lim)) begin
                    n_new_integ = lim;
                end else if (integ_t < -21'(lim)) begin
                    n_new_integ = -lim;
                end else begin
                    n_new_integ = 20'(integ_t);
                end
                n_sum = '0;
                n_state = StP;
            end
            StP: begin
                if (!mrsp.busy && !mrsp.done) begin
                    mreq.start = 1'b1;
                    mreq.mcand = 64'(abs_err) * 64'(r_prop_gain);
                    mreq.mplier = dkpc_pkg::PropK;
                end else if (mrsp.done) begin
                    n_sum = r_err[16] ? r_sum - signed'(mrsp.prod)
                                      : r_sum + signed'(mrsp.prod);
                    n_state = StI;
                end
            end
            StI: begin
                if (!mrsp.busy && !mrsp.done) begin
                    mreq.start = 1'b1;
                    mreq.mcand = r_new_integ[19] ? 64'(-21'(r_new_integ))
                                                 : 64'(r_new_integ);
                    mreq.mplier = 32'(r_integ_gain);
                end else if (mrsp.done) begin
                    n_sum = r_new_integ[19] ? r_sum - signed'(mrsp.prod << 16)
                                            : r_sum + signed'(mrsp.prod << 16);
                    n_state = StD;
                end
            end
            StD: begin
                if (!mrsp.busy && !mrsp.done) begin
                    mreq.start = 1'b1;
                    mreq.mcand = r_speed[15] ? 64'(-17'(r_speed)) : 64'(r_speed);
                    mreq.mplier = 32'(r_deriv_gain);
                end else if (mrsp.done) begin
                    n_sum = r_speed[15] ? r_sum - signed'(mrsp.prod << 24)
                                        : r_sum + signed'(mrsp.prod << 24);
                    n_state = StRound;
                end
            end
            StRound: begin
                n_integ = r_new_integ;
                if (vfull > 29'(vlim)) begin
                    n_v = 16'(vlim);
                end else if (vfull < -29'(vlim)) begin
                    n_v = 16'(-vlim);
                end else begin
                    n_v = 16'(vfull);
                end
                n_state = StOut;
            end
            StOut: begin
                abs_v = r_v[15] ? 16'(-r_v) : r_v;
                drv = r_v[15] ? r_elec + 16'd16384 : r_elec - 16'd16384;
                sect_prod = 20'(drv) * 20'd12;
                n_gates = (abs_v >= 16'(r_dead_band))
                          ? dkpc_pkg::f_gates(sect_prod[19:16]) : 6'd0;
                n_state = StWait;
            end
            StWait: begin
                if (!r_ovalid || out_acc) begin
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mech <= i_mech_angle;
            r_elec <= i_elec_angle;
            r_speed <= i_speed;
            r_us <= (i_elapsed_us == 16'd0) ? 16'd1000 : i_elapsed_us;
        end
        r_err <= n_err;
        r_new_integ <= n_new_integ;
        r_sum <= n_sum;
        r_tmp <= n_tmp;
        r_v <= n_v;
        r_gates <= n_gates;
        if (r_state == StWait && (!r_ovalid || out_acc)) begin
            r_ov <= r_v;
            r_odet <= r_idx;
            r_ogates <= r_gates;
        end
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_idx <= '0;
            r_integ <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_integ <= n_integ;
            if (r_state == StWait && (!r_ovalid || out_acc)) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_drive_voltage = r_ov;
    assign o_detent = r_odet;
    assign o_gate_pattern = r_ogates;

    // The detent index never leaves its range.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < 4'(dkpc_pkg::Detents))
        else $error("detent index out of range");

    // No request is taken while one is being worked.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> !in_acc)
        else $error("request accepted while busy");

    // A reported drive never exceeds the voltage limit.
    a_volt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StOut) |-> (r_v <= $signed({1'b0, r_volt_limit})
                                && r_v >= -$signed({1'b0, r_volt_limit})))
        else $error("drive beyond limit");
endmodule
